>>> sv/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and codes of the first-fit range allocator
// Address, request and status types, and the layout of one table entry.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned BUSY_W   = 7;
	localparam int unsigned STATUS_W = 3;

	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [1:0]          req_code_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [BUSY_W-1:0]   busy_t;
	typedef logic [0:0]          cfg_index_t;

	localparam req_code_t REQ_ALLOC   = 2'd0;
	localparam req_code_t REQ_RESERVE = 2'd1;
	localparam req_code_t REQ_RELEASE = 2'd2;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_NO_GAP    = 3'd1;
	localparam status_t ST_NOT_FOUND = 3'd2;
	localparam status_t ST_FULL      = 3'd3;
	localparam status_t ST_ZERO      = 3'd4;

	localparam cfg_index_t CFG_BASE  = 1'b0;
	localparam cfg_index_t CFG_LIMIT = 1'b1;

	// One busy range [lo, hi)
	typedef struct packed {
		addr_t lo;
		addr_t hi;
	} entry_t;

endpackage

>>> sv/ffra_if.sv
// ----------------------------------------------------------------------------
// ffra_req_if / ffra_rsp_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ffra_req_if;
	import ffra_pkg::*;

	logic      valid;
	logic      ready;
	req_code_t req_type;
	addr_t     size_bytes;
	addr_t     range_begin;
	addr_t     range_end;

	modport source (output valid, output req_type, output size_bytes,
		output range_begin, output range_end, input ready);
	modport sink (input valid, input req_type, input size_bytes,
		input range_begin, input range_end, output ready);
endinterface

interface ffra_rsp_if;
	import ffra_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	addr_t   alloc_address;
	busy_t   busy_count;

	modport source (output valid, output status, output alloc_address,
		output busy_count, input ready);
	modport sink (input valid, input status, input alloc_address,
		input busy_count, output ready);
endinterface

>>> sv/first_fit_range_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator: first-fit allocator over sorted busy ranges
// Keeps up to MAX_RANGES busy address ranges sorted by start and serves
// allocate, reserve and release requests, one result per request.
// ----------------------------------------------------------------------------
// The block takes one request at a time; req.ready is high only while the
// sequencer is idle, and each request yields exactly one result on rsp. The
// busy table lives in one RAM with a registered read, so every table step
// is a read followed by a test or a write. Release walks the entries up to
// the matching one and then shifts the later entries down to close the
// hole; reserve walks down from the top, shifting every entry whose start
// lies above the new start up by one; allocate first rounds the size up to
// whole pages, then walks the entries until a gap is found, then inserts.
// The walk and the shift that follows together touch each entry about once.
// Requests that fail a quick check (zero size, full table) and requests of
// unknown type go straight to the result. One result waits in the output
// register without stalling the next request. The user must write
// memory_base and memory_limit through the cfg port only while the block is
// idle; the block itself does not enforce this. Table contents have no
// reset: only entries below the busy count are ever used.
// ----------------------------------------------------------------------------
module first_fit_range_allocator #(
	parameter int unsigned MAX_RANGES = 64,
	parameter int unsigned PAGE_BYTES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ffra_req_if.sink             req,
	ffra_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  ffra_pkg::cfg_index_t cfg_index,
	input  ffra_pkg::addr_t      cfg_data
);
	import ffra_pkg::*;

	localparam int unsigned AW = $clog2(MAX_RANGES);
	localparam int unsigned CW = $clog2(MAX_RANGES + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROUND,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_INS_RD,
		S_INS_CHK,
		S_DEL_RD,
		S_DEL_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FIN
	} state_t;

	state_t  state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	addr_t   base_q;
	addr_t   limit_q;
	addr_t   size_q;
	addr_t   gap_q;
	addr_t   rel_q;
	addr_t   nb_q;
	addr_t   ne_q;
	addr_t   addr_q;
	status_t status_q;

	logic    rsp_valid_q;
	status_t rsp_status_q;
	addr_t   rsp_addr_q;
	busy_t   rsp_busy_q;

	logic          req_acc;
	logic          full;
	logic          rnd_start;
	logic          rnd_done;
	logic [32:0]   rnd_size;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_wdata;
	entry_t        ram_rdata;

	addr_t         fit_op;
	logic          fit;
	logic          rsp_free;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign full      = (count_q == CW'(MAX_RANGES));
	assign rnd_start = req_acc && (req.req_type == REQ_ALLOC) &&
		(req.size_bytes != '0) && !full;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// Shared gap test: against the entry just read while walking, against
	// memory_limit once the walk runs past the last entry
	assign fit_op = (state_q == S_SCAN_RD) ? limit_q : ram_rdata.lo;
	assign fit    = (fit_op >= gap_q) && ((fit_op - gap_q) >= size_q);

	ffra_round #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rnd_start),
		.size_bytes(req.size_bytes),
		.done      (rnd_done),
		.rounded   (rnd_size)
	);

	ffra_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_RANGES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Table port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_raddr = idx_q[AW-1:0];
		ram_wdata = '{lo: nb_q, hi: ne_q};
		unique case (state_q)
			S_INS_RD: begin
				if (idx_q == '0) begin
					// reached the bottom: new entry goes first
					ram_we = 1'b1;
				end else begin
					ram_raddr = AW'(idx_q - 1'b1);
				end
			end
			S_INS_CHK: begin
				// move a larger start up one slot, else drop the new entry here
				ram_we = 1'b1;
				if (ram_rdata.lo > nb_q) begin
					ram_wdata = ram_rdata;
				end
			end
			S_SHIFT_RD: begin
				ram_raddr = AW'(idx_q + 1'b1);
			end
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			limit_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_data;
				CFG_LIMIT: limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drop a taken result unless a new one replaces it at this edge
			if (rsp_valid_q && rsp.ready && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						rel_q    <= req.range_begin;
						nb_q     <= req.range_begin;
						ne_q     <= req.range_end;
						addr_q   <= '0;
						status_q <= ST_OK;
						idx_q    <= '0;
						unique case (req.req_type)
							REQ_ALLOC: begin
								if (req.size_bytes == '0) begin
									status_q <= ST_ZERO;
									state_q  <= S_FIN;
								end else if (full) begin
									status_q <= ST_FULL;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_ROUND;
								end
							end
							REQ_RESERVE: begin
								if (full) begin
									status_q <= ST_FULL;
									state_q  <= S_FIN;
								end else begin
									idx_q   <= count_q;
									state_q <= S_INS_RD;
								end
							end
							REQ_RELEASE: begin
								state_q <= S_DEL_RD;
							end
							default: begin
								// unknown type: answer ok, touch nothing
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_ROUND: begin
					if (rnd_done) begin
						if (rnd_size[32]) begin
							status_q <= ST_NO_GAP;
							state_q  <= S_FIN;
						end else begin
							size_q  <= rnd_size[31:0];
							gap_q   <= base_q;
							idx_q   <= '0;
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (idx_q == count_q) begin
						// tail gap up to memory_limit
						if (fit) begin
							nb_q    <= gap_q;
							ne_q    <= gap_q + size_q;
							addr_q  <= gap_q;
							idx_q   <= count_q;
							state_q <= S_INS_RD;
						end else begin
							status_q <= ST_NO_GAP;
							state_q  <= S_FIN;
						end
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (fit) begin
						nb_q    <= gap_q;
						ne_q    <= gap_q + size_q;
						addr_q  <= gap_q;
						idx_q   <= count_q;
						state_q <= S_INS_RD;
					end else begin
						if (ram_rdata.hi > gap_q) begin
							gap_q <= ram_rdata.hi;
						end
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_INS_RD: begin
					if (idx_q == '0) begin
						count_q <= count_q + 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_INS_CHK;
					end
				end
				S_INS_CHK: begin
					if (ram_rdata.lo > nb_q) begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_INS_RD;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_DEL_RD: begin
					if (idx_q == count_q) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_DEL_CHK;
					end
				end
				S_DEL_CHK: begin
					// match needs an exact start and an end that differs from the start
					if ((ram_rdata.lo == rel_q) && (ram_rdata.hi != rel_q)) begin
						state_q <= S_SHIFT_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_DEL_RD;
					end
				end
				S_SHIFT_RD: begin
					if ((idx_q + 1'b1) == count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_SHIFT_RD;
				end
				S_FIN: begin
					// hold until the output register is free
					if (rsp_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_addr_q   <= addr_q;
						rsp_busy_q   <= BUSY_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.alloc_address = rsp_addr_q;
	assign rsp.busy_count    = rsp_busy_q;

endmodule

>>> sv/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffra_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/ffra_round.sv
// ----------------------------------------------------------------------------
// ffra_round: page round-up unit
// Rounds a byte size up to a multiple of PAGE_BYTES with one shared
// multiplier: reciprocal multiply in two halves, then scale the quotient
// back by the page size. The 33-bit result flags an overflow in bit 32.
// ----------------------------------------------------------------------------
module ffra_round #(
	parameter int unsigned PAGE_BYTES = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ffra_pkg::addr_t size_bytes,
	output logic            done,
	output logic [32:0]     rounded
);
	import ffra_pkg::*;

	localparam int unsigned XW  = ADDR_W + 1;
	localparam int unsigned LW  = $clog2(PAGE_BYTES);
	localparam int unsigned SH  = XW + LW;
	localparam int unsigned MW  = XW + 1;
	localparam int unsigned HW  = MW / 2;
	localparam int unsigned PW  = LW + 1;
	localparam int unsigned BW  = (HW > PW) ? HW : PW;
	localparam int unsigned PRW = XW + BW;
	localparam int unsigned ACW = XW + MW;
	// ceil(2^SH / PAGE_BYTES): exact quotient for any dividend below 2^XW
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) /
		64'(PAGE_BYTES));

	typedef enum logic [1:0] {
		R_IDLE,
		R_HI,
		R_LO,
		R_PAGE
	} phase_t;

	phase_t         phase_q;
	logic           done_q;
	logic [XW-1:0]  x_q;
	logic [ACW-1:0] acc_q;
	logic [XW-1:0]  res_q;
	logic [XW-1:0]  quot;
	logic [XW-1:0]  mul_a;
	logic [BW-1:0]  mul_b;
	logic [PRW-1:0] mul_p;

	assign quot = XW'(acc_q >> SH);

	// Shared multiplier: upper and lower reciprocal halves, then the page size
	always_comb begin
		mul_a = x_q;
		mul_b = BW'(RECIP[MW-1:HW]);
		unique case (phase_q)
			R_LO: begin
				mul_b = BW'(RECIP[HW-1:0]);
			end
			R_PAGE: begin
				mul_a = quot;
				mul_b = BW'(PAGE_BYTES);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = PRW'(mul_a) * PRW'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= R_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				R_IDLE: begin
					if (start) begin
						phase_q <= R_HI;
					end
				end
				R_HI: begin
					phase_q <= R_LO;
				end
				R_LO: begin
					phase_q <= R_PAGE;
				end
				R_PAGE: begin
					phase_q <= R_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					phase_q <= R_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= XW'(size_bytes) + XW'(PAGE_BYTES - 1);
		end
		case (phase_q)
			R_HI:    acc_q <= ACW'(mul_p) << HW;
			R_LO:    acc_q <= acc_q + ACW'(mul_p);
			R_PAGE:  res_q <= XW'(mul_p);
			default: begin
			end
		endcase
	end

	assign done    = done_q;
	assign rounded = res_q;

endmodule

>>> sim/first_fit_range_allocator_check.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator_check: outcome checker for the range allocator
// Watches the request, result and register ports, keeps its own busy-range
// table, predicts the outcome of every accepted request and compares each
// result with the oldest outcome still awaited.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_check #(
	parameter int unsigned MAX_RANGES = 64,
	parameter int unsigned PAGE_BYTES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ffra_req_if                  req,
	ffra_rsp_if                  rsp,
	input  logic                 cfg_we,
	input  ffra_pkg::cfg_index_t cfg_index,
	input  ffra_pkg::addr_t      cfg_data,
	output int                   mismatch_count,
	output int                   awaited
);
	timeunit 1ns;
	timeprecision 1ps;
	import ffra_pkg::*;

	typedef struct packed {
		status_t status;
		addr_t   addr;
		busy_t   busy;
	} outcome_t;

	addr_t       lo_tab [MAX_RANGES];
	addr_t       hi_tab [MAX_RANGES];
	int unsigned used;
	addr_t       base_reg;
	addr_t       limit_reg;
	outcome_t    due_outcomes [$];

	task automatic report(string what);
		mismatch_count++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Insert in front of the first entry with a strictly greater start.
	function automatic void place_range(addr_t lo, addr_t hi);
		int unsigned pos;
		pos = used;
		for (int unsigned k = 0; k < used; k++) begin
			if (lo_tab[k] > lo) begin
				pos = k;
				break;
			end
		end
		for (int unsigned k = used; k > pos; k--) begin
			lo_tab[k] = lo_tab[k-1];
			hi_tab[k] = hi_tab[k-1];
		end
		lo_tab[pos] = lo;
		hi_tab[pos] = hi;
		used++;
	endfunction

	function automatic outcome_t serve_request(req_code_t kind, addr_t size_in, addr_t lo,
		addr_t hi);
		outcome_t          res;
		longint unsigned   need;
		longint unsigned   gap_lo;
		longint unsigned   entry_lo;
		bit                placed;
		int                hit;
		res = '{status: ST_OK, addr: '0, busy: '0};
		case (kind)
			REQ_ALLOC: begin
				if (size_in == '0) begin
					res.status = ST_ZERO;
				end else if (used >= MAX_RANGES) begin
					res.status = ST_FULL;
				end else begin
					res.status = ST_NO_GAP;
					need = size_in;
					need = ((need + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
					if (need <= 64'hFFFF_FFFF) begin
						gap_lo = base_reg;
						placed = 1'b0;
						for (int unsigned k = 0; k < used && !placed; k++) begin
							entry_lo = lo_tab[k];
							if (entry_lo >= gap_lo && entry_lo - gap_lo >= need) begin
								placed = 1'b1;
							end else if (hi_tab[k] > gap_lo) begin
								gap_lo = hi_tab[k];
							end
						end
						if (!placed && limit_reg >= gap_lo && limit_reg - gap_lo >= need) begin
							placed = 1'b1;
						end
						if (placed) begin
							place_range(addr_t'(gap_lo), addr_t'(gap_lo + need));
							res.status = ST_OK;
							res.addr = addr_t'(gap_lo);
						end
					end
				end
			end
			REQ_RESERVE: begin
				if (used >= MAX_RANGES) begin
					res.status = ST_FULL;
				end else begin
					place_range(lo, hi);
				end
			end
			REQ_RELEASE: begin
				hit = -1;
				for (int unsigned k = 0; k < used; k++) begin
					if (lo_tab[k] == lo && hi_tab[k] != lo) begin
						hit = k;
						break;
					end
				end
				if (hit < 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					for (int unsigned k = hit; k + 1 < used; k++) begin
						lo_tab[k] = lo_tab[k+1];
						hi_tab[k] = hi_tab[k+1];
					end
					used--;
				end
			end
			default: ;
		endcase
		res.busy = busy_t'(used);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t oldest;
		if (!arst_n) begin
			used = 0;
			base_reg = '0;
			limit_reg = '1;
			due_outcomes.delete();
			awaited <= 0;
		end else begin
			// Results first: one accepted at this edge belongs to an older request.
			if (rsp.valid && rsp.ready) begin
				if (due_outcomes.size() == 0) begin
					report($sformatf("result with nothing awaited (status %0d)", rsp.status));
				end else begin
					oldest = due_outcomes.pop_front();
					if (rsp.status !== oldest.status)
						report($sformatf("status %0d, predicted %0d", rsp.status, oldest.status));
					if (rsp.alloc_address !== oldest.addr)
						report($sformatf("alloc_address %h, predicted %h", rsp.alloc_address,
							oldest.addr));
					if (rsp.busy_count !== oldest.busy)
						report($sformatf("busy_count %0d, predicted %0d", rsp.busy_count,
							oldest.busy));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE:  base_reg = cfg_data;
					CFG_LIMIT: limit_reg = cfg_data;
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				due_outcomes.push_back(serve_request(req.req_type, req.size_bytes,
					req.range_begin, req.range_end));
			end
			awaited <= due_outcomes.size();
		end
	end

endmodule

>>> sim/first_fit_range_allocator_test.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator_test: top of the range allocator testbench
// Drives a directed request list and then random phases under several memory
// windows and handshake idling patterns; the checker beside the block
// predicts every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ffra_pkg::*;

	localparam int unsigned MAX_RANGES  = 64;
	localparam int unsigned PAGE_BYTES  = 4096;
	localparam int unsigned PHASE_COUNT = 8;
	localparam int unsigned PHASE_REQS  = 140;
	// Idle time after the last result, to watch for stray results.
	localparam int unsigned TAIL_CYCLES = 400;
	// The one code the request field allows but the block does not define
	localparam req_code_t   REQ_UNUSED  = 2'd3;

	// Flavor of a stretch of random requests
	typedef enum logic [1:0] {BLEND_FILL, BLEND_DRAIN, BLEND_ANY} blend_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	cfg_index_t  cfg_index;
	addr_t       cfg_data;
	int          mismatch_count;
	int          awaited;
	int unsigned sender_idle_pct;
	int unsigned sink_stall_pct;
	addr_t       window_base;
	addr_t       reserved_starts [$];

	ffra_req_if req_ch ();
	ffra_rsp_if rsp_ch ();

	first_fit_range_allocator #(
		.MAX_RANGES(MAX_RANGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	first_fit_range_allocator_check #(
		.MAX_RANGES(MAX_RANGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.awaited        (awaited)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: stall at random, at the rate of the current phase.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#30_000_000;
		$display("[first_fit_range_allocator] ERROR");
		$finish;
	end

	// Drop valid and hold until every awaited result is back and the block
	// is ready again. The first edge lets the awaited count catch up with a
	// request accepted at the current edge.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0 || !req_ch.ready) @(posedge clk);
	endtask

	// Write both window registers while the block is idle.
	task automatic set_window(addr_t lo, addr_t hi);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BASE;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_LIMIT;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_base = lo;
	endtask

	// Present one request and hold it until it is taken. Valid stays high
	// afterwards so back-to-back requests need no extra assignment.
	task automatic issue_request(req_code_t kind, addr_t size, addr_t lo, addr_t hi);
		int unsigned gap;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < sender_idle_pct) gap++;
		if ($urandom_range(59) == 0) begin
			// Now and then hold off until the block has emptied completely.
			drain_results();
		end else if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.size_bytes  <= size;
		req_ch.range_begin <= lo;
		req_ch.range_end   <= hi;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// A page-aligned offset into the current window, where allocations land.
	function automatic addr_t near_window(int unsigned span);
		return window_base + addr_t'(PAGE_BYTES * $urandom_range(span));
	endfunction

	// Mostly a few pages, with zero, rounding overflow and full-width sizes.
	function automatic addr_t pick_size();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 5) return '0;
		if (roll < 10) return $urandom();
		if (roll < 13) return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_F001);
		return $urandom_range(4 * PAGE_BYTES, 1);
	endfunction

	task automatic random_request(blend_t blend);
		int unsigned roll;
		int unsigned idx;
		req_code_t   kind;
		addr_t       size;
		addr_t       lo;
		addr_t       hi;
		roll = $urandom_range(99);
		case (blend)
			BLEND_FILL:
				kind = (roll < 60) ? REQ_RESERVE : (roll < 95) ? REQ_ALLOC :
					(roll < 98) ? REQ_RELEASE : REQ_UNUSED;
			BLEND_DRAIN:
				kind = (roll < 75) ? REQ_RELEASE : (roll < 90) ? REQ_ALLOC :
					(roll < 97) ? REQ_RESERVE : REQ_UNUSED;
			default:
				kind = (roll < 35) ? REQ_ALLOC : (roll < 65) ? REQ_RESERVE :
					(roll < 95) ? REQ_RELEASE : REQ_UNUSED;
		endcase
		// Unused fields still carry random bits.
		size = pick_size();
		lo   = $urandom();
		hi   = $urandom();
		roll = $urandom_range(99);
		case (kind)
			REQ_RESERVE: begin
				if (roll < 70) begin
					lo = near_window(80);
					hi = lo + addr_t'(PAGE_BYTES * $urandom_range(4, 1));
				end else if (roll < 80) begin
					hi = lo;
				end else if (roll < 90) begin
					hi = lo - addr_t'($urandom_range(4 * PAGE_BYTES, 1));
				end
				if (reserved_starts.size() < 256) reserved_starts.push_back(lo);
			end
			REQ_RELEASE: begin
				if (roll < 50 && reserved_starts.size() > 0) begin
					idx = $urandom_range(reserved_starts.size() - 1);
					lo = reserved_starts[idx];
					reserved_starts.delete(idx);
				end else if (roll < 90) begin
					lo = near_window(70);
				end
			end
			default: ;
		endcase
		issue_request(kind, size, lo, hi);
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned stretch;
		addr_t       lo;
		addr_t       hi;

		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_ALLOC;
		req_ch.size_bytes  <= '0;
		req_ch.range_begin <= '0;
		req_ch.range_end   <= '0;
		cfg_we             <= 1'b0;
		cfg_index          <= CFG_BASE;
		cfg_data           <= '0;
		arst_n             <= 1'b0;
		sender_idle_pct    = 0;
		sink_stall_pct     = 0;
		window_base        = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed list on the reset window [0, 0xFFFFFFFF) with an empty table
		issue_request(REQ_ALLOC, '0, '0, '0);                        // zero size
		issue_request(REQ_RELEASE, '0, '0, '0);                      // nothing to release
		issue_request(REQ_UNUSED, '1, '1, '1);                       // undefined type
		issue_request(REQ_ALLOC, 32'd1, '0, '0);                     // one byte, one page
		issue_request(REQ_ALLOC, 32'h0000_1000, '0, '0);
		issue_request(REQ_ALLOC, 32'hFFFF_FFFF, '0, '0);             // rounds past 32 bits
		issue_request(REQ_ALLOC, 32'hFFFF_F000, '0, '0);             // no gap that large
		issue_request(REQ_RESERVE, '0, 32'h0000_8000, 32'h0000_9000);
		issue_request(REQ_ALLOC, 32'h0000_5000, '0, '0);             // fits the hole below
		issue_request(REQ_ALLOC, 32'h0000_2000, '0, '0);             // hole too small, skip
		issue_request(REQ_RESERVE, '0, 32'h0000_3000, 32'h0000_1000); // reversed, overlapping
		issue_request(REQ_RESERVE, '0, 32'h0000_4000, 32'h0000_4000); // empty range
		issue_request(REQ_RELEASE, '0, 32'h0000_4000, '0);           // empty entry never matches
		issue_request(REQ_RESERVE, '0, '1, '0);                       // top start, zero end
		issue_request(REQ_RESERVE, '0, '0, '1);                       // covers everything
		issue_request(REQ_RELEASE, '0, '0, '0);                       // first of equal starts
		issue_request(REQ_RELEASE, '0, 32'h0000_8000, '0);
		issue_request(REQ_ALLOC, 32'h0000_1000, '0, '0);             // walk past the big range
		issue_request(REQ_RELEASE, '0, '1, '0);
		issue_request(REQ_RELEASE, '0, '0, '0);
		issue_request(REQ_RELEASE, '0, 32'h0000_1000, '0);

		// Random phases: each under its own window and idling pattern. The
		// table carries over from phase to phase.
		for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
			drain_results();
			case (phase)
				0: begin lo = '0;            hi = '1;            end
				1: begin lo = 32'h4000_0000; hi = 32'h4004_0000; end // 64 pages only
				2: begin lo = 32'hFFFF_0000; hi = '1;            end // top of the space
				3: begin lo = '0;            hi = '0;            end // nothing fits
				4: begin lo = '1;            hi = '0;            end // limit below base
				5: begin
					lo = $urandom();
					hi = lo + addr_t'($urandom_range(32'h0010_0000));
				end
				6: begin lo = 32'h1234_5678; hi = 32'h1240_0000; end // unaligned base
				default: begin lo = '0; hi = '1; end
			endcase
			set_window(lo, hi);
			case (phase % 4)
				0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin sender_idle_pct = 46; sink_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  sink_stall_pct = 46; end
				default: begin sender_idle_pct = 6; sink_stall_pct = 6; end
			endcase
			// Stretches that lean toward filling the table, emptying it, or a mix.
			sent = 0;
			while (sent < PHASE_REQS) begin
				stretch = $urandom_range(90, 30);
				repeat (stretch) random_request(blend_t'($urandom_range(2)));
				sent += stretch;
			end
		end

		// Wind down: collect every result, then watch for strays.
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[first_fit_range_allocator] OK");
		end else begin
			$display("[first_fit_range_allocator] ERROR");
		end
		$finish;
	end

endmodule
